FILE: rtl/core/run_length_escape_encoder_core_defines.svh
// ----------------------------------------------------------------------------
// Run-length escape encoder - assertion macros
// Shared assertion forms for the checker of the encoder core.
// ----------------------------------------------------------------------------
`ifndef RUN_LENGTH_ESCAPE_ENCODER_CORE_DEFINES_SVH
`define RUN_LENGTH_ESCAPE_ENCODER_CORE_DEFINES_SVH

// Property checked only outside reset
`define RLEE_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rlee assertion failed");

// Property that also watches the reset itself
`define RLEE_ASSERT_RST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("rlee reset assertion failed");

`endif

FILE: rtl/core/rlee_pkg.sv
// ----------------------------------------------------------------------------
// Run-length escape encoder - package
// Payload types, group descriptors and constants shared by the core.
// ----------------------------------------------------------------------------
`default_nettype none

package rlee_pkg;

    // Input item
    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_stream;
    } t_in;

    // Result item
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } t_out;

    // One group: byte and its extra-copy count
    typedef struct packed {
        logic [7:0] byte_val;
        logic [3:0] count;
    } t_group;

    // Work for one input item: g0 always present, g1 optional
    typedef struct packed {
        t_group g0;
        logic   g1_valid;
        t_group g1;
    } t_entry;

    // Configuration register indexes
    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_ESCAPE_BYTE = 2'd0;
    localparam t_cfg_idx CFG_MAX_EXTRA   = 2'd1;

    localparam logic [7:0] ESCAPE_RESET = 8'd36;   // '$'
    localparam logic [3:0] MAX_RESET    = 4'd9;
    localparam logic [3:0] MAX_LIMIT    = 4'd9;
    localparam logic [3:0] MAX_FLOOR    = 4'd1;
    localparam logic [7:0] DIGIT_BASE   = 8'h30;   // '0'

endpackage

`default_nettype wire

FILE: rtl/core/rlee_front.sv
// ----------------------------------------------------------------------------
// Run-length escape encoder - front end
// Holds the current run and classifies each byte into zero, one or two
// finished groups, which are pushed to the group queue as one entry.
// ----------------------------------------------------------------------------
`default_nettype none

module rlee_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire rlee_pkg::t_in i_item,
    input  wire logic [3:0]    i_max_extra,
    output logic               o_push,
    output rlee_pkg::t_entry   o_entry
);
    import rlee_pkg::*;

    logic [7:0] r_held_byte, n_held_byte;
    logic       r_held_valid, n_held_valid;
    logic [3:0] r_extra, n_extra;

    logic [3:0] max_eff;
    logic [3:0] extra_inc;
    logic       same_run;

    // Clamp the run limit into 1..9
    always_comb begin
        if (i_max_extra < MAX_FLOOR) begin
            max_eff = MAX_FLOOR;
        end else if (i_max_extra > MAX_LIMIT) begin
            max_eff = MAX_LIMIT;
        end else begin
            max_eff = i_max_extra;
        end
    end

    assign extra_inc = r_extra + 4'd1;
    assign same_run  = r_held_valid && (i_item.in_byte == r_held_byte) && (r_extra < max_eff);

    // Classify the byte into groups and the next run state
    always_comb begin
        n_held_byte  = r_held_byte;
        n_held_valid = r_held_valid;
        n_extra      = r_extra;
        o_push       = 1'b0;
        o_entry      = '0;
        if (i_accept) begin
            if (same_run) begin
                // Run grows; flush at the limit or on the end mark
                if ((extra_inc >= max_eff) || i_item.end_of_stream) begin
                    o_push           = 1'b1;
                    o_entry.g0       = '{byte_val: r_held_byte, count: extra_inc};
                    n_held_valid     = 1'b0;
                    n_extra          = '0;
                end else begin
                    n_extra          = extra_inc;
                end
            end else begin
                // New byte: flush the old run, the new one may flush at once
                n_held_byte = i_item.in_byte;
                n_extra     = '0;
                if (r_held_valid) begin
                    o_push     = 1'b1;
                    o_entry.g0 = '{byte_val: r_held_byte, count: r_extra};
                    if (i_item.end_of_stream) begin
                        o_entry.g1_valid = 1'b1;
                        o_entry.g1       = '{byte_val: i_item.in_byte, count: 4'd0};
                    end
                end else if (i_item.end_of_stream) begin
                    o_push     = 1'b1;
                    o_entry.g0 = '{byte_val: i_item.in_byte, count: 4'd0};
                end
                n_held_valid = !i_item.end_of_stream;
            end
        end
    end

    // Run state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_byte  <= '0;
            r_held_valid <= 1'b0;
            r_extra      <= '0;
        end else begin
            r_held_byte  <= n_held_byte;
            r_held_valid <= n_held_valid;
            r_extra      <= n_extra;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/rlee_queue.sv
// ----------------------------------------------------------------------------
// Run-length escape encoder - group queue
// Short register queue of group entries between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module rlee_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire rlee_pkg::t_entry i_entry,
    input  wire logic            i_pop,
    output rlee_pkg::t_entry     o_head,
    output logic                 o_empty,
    output logic                 o_full
);
    import rlee_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/rlee_back.sv
// ----------------------------------------------------------------------------
// Run-length escape encoder - back end
// Walks the queue head one output byte per cycle unless results stall: byte,
// then marker and count digit for repeated groups, into a registered result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rlee_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire rlee_pkg::t_entry i_head,
    input  wire logic             i_head_empty,
    output logic                  o_head_pop,
    input  wire logic [7:0]       i_escape_byte,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output rlee_pkg::t_out        o_out
);
    import rlee_pkg::*;

    typedef enum logic [2:0] {
        S_G0_BYTE,
        S_G0_ESC,
        S_G0_DIGIT,
        S_G1_BYTE,
        S_G1_ESC,
        S_G1_DIGIT
    } t_step;

    t_step      r_step, n_step;
    t_out       r_out, n_out;
    logic       r_out_valid, n_out_valid;
    logic       advance;
    logic       entry_done;
    logic [7:0] cur_byte;

    assign advance = !r_out_valid || i_pop;

    // Byte for the current step and the step after it
    always_comb begin
        cur_byte   = i_head.g0.byte_val;
        n_step     = S_G0_BYTE;
        entry_done = 1'b0;
        unique case (r_step)
            S_G0_BYTE: begin
                cur_byte = i_head.g0.byte_val;
                if (i_head.g0.count != '0) begin
                    n_step = S_G0_ESC;
                end else if (i_head.g1_valid) begin
                    n_step = S_G1_BYTE;
                end else begin
                    entry_done = 1'b1;
                end
            end
            S_G0_ESC: begin
                cur_byte = i_escape_byte;
                n_step   = S_G0_DIGIT;
            end
            S_G0_DIGIT: begin
                cur_byte = DIGIT_BASE + {4'd0, i_head.g0.count};
                if (i_head.g1_valid) begin
                    n_step = S_G1_BYTE;
                end else begin
                    entry_done = 1'b1;
                end
            end
            S_G1_BYTE: begin
                cur_byte = i_head.g1.byte_val;
                if (i_head.g1.count != '0) begin
                    n_step = S_G1_ESC;
                end else begin
                    entry_done = 1'b1;
                end
            end
            S_G1_ESC: begin
                cur_byte = i_escape_byte;
                n_step   = S_G1_DIGIT;
            end
            S_G1_DIGIT: begin
                cur_byte   = DIGIT_BASE + {4'd0, i_head.g1.count};
                entry_done = 1'b1;
            end
            default: begin
                entry_done = 1'b1;
            end
        endcase
    end

    // Load the result stage whenever it is free or being taken
    always_comb begin
        n_out       = r_out;
        n_out_valid = r_out_valid;
        o_head_pop  = 1'b0;
        if (advance) begin
            n_out_valid = !i_head_empty;
            if (!i_head_empty) begin
                n_out      = '{out_byte: cur_byte, last_of_run: entry_done};
                o_head_pop = entry_done;
            end
        end
    end

    // Step sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= S_G0_BYTE;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (advance && !i_head_empty) begin
                r_step <= entry_done ? S_G0_BYTE : n_step;
            end
        end
        r_out <= n_out;
    end

    assign o_empty = !r_out_valid;
    assign o_out   = r_out;

endmodule

`default_nettype wire

FILE: rtl/core/run_length_escape_encoder_core.sv
// Path: an accepted byte that closes a group has its entry written into the
// group queue at the accepting edge; the result register is then loaded from
// the queue head once the result stage is free or being taken.
// Throughput: one byte accepted per cycle while the group queue has room; one
// result per cycle while results are taken; a byte yields 0 to 4 result bytes.
// Reset: synchronous active low; clears the held run, queue and result stage,
// and loads escape byte '$' and run limit 9. No clearing pass.
// ----------------------------------------------------------------------------
// Run-length escape encoder core
// Front end classifies bytes into groups, a short queue decouples it from the
// back end, which spells each group out one byte per cycle unless results stall.
// ----------------------------------------------------------------------------
`default_nettype none

module run_length_escape_encoder_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // input side
    input  wire logic               push,
    output logic                    full,
    input  wire rlee_pkg::t_in      i_in,
    // result side
    output logic                    empty,
    input  wire logic               pop,
    output rlee_pkg::t_out          o_out,
    // configuration
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire rlee_pkg::t_cfg_idx i_cfg_index,
    input  wire logic [7:0]         i_cfg_data
);
    import rlee_pkg::*;

    logic [7:0] r_escape_byte;
    logic [3:0] r_max_extra;
    logic       in_accept;
    logic       q_push, q_pop, q_empty, q_full;
    t_entry     q_in, q_head;

    assign o_cfg_ready = 1'b1;
    assign full        = q_full;
    assign in_accept   = push && !q_full;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_escape_byte <= ESCAPE_RESET;
            r_max_extra   <= MAX_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_ESCAPE_BYTE: r_escape_byte <= i_cfg_data;
                CFG_MAX_EXTRA:   r_max_extra   <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    rlee_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_item      (i_in),
        .i_max_extra (r_max_extra),
        .o_push      (q_push),
        .o_entry     (q_in)
    );

    rlee_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    rlee_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (q_head),
        .i_head_empty  (q_empty),
        .o_head_pop    (q_pop),
        .i_escape_byte (r_escape_byte),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_out         (o_out)
    );

endmodule

`default_nettype wire

FILE: rtl/core/rlee_checker.sv
// ----------------------------------------------------------------------------
// Run-length escape encoder - port checker
// Watches the core's ports over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "run_length_escape_encoder_core_defines.svh"

module rlee_checker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               push,
    input  wire logic               full,
    input  wire rlee_pkg::t_in      i_in,
    input  wire logic               empty,
    input  wire logic               pop,
    input  wire rlee_pkg::t_out     o_out,
    input  wire logic               i_cfg_valid,
    input  wire logic               o_cfg_ready,
    input  wire rlee_pkg::t_cfg_idx i_cfg_index,
    input  wire logic [7:0]         i_cfg_data
);
    import rlee_pkg::*;

    // Reset leaves nothing to deliver and room for input
    `RLEE_ASSERT_RST(a_reset_clear, i_clk, !i_rst_n |=> (empty && !full))

    // A waiting result stays put until it is taken
    `RLEE_ASSERT(a_hold, i_clk, i_rst_n, (!empty && !pop) |=> (!empty && $stable(o_out)))

    // A group in flight is spelt out without gaps once its bytes start moving
    `RLEE_ASSERT(a_no_gap, i_clk, i_rst_n, (!empty && pop && !o_out.last_of_run) |=> !empty)

    // Configuration writes are never back-pressured
    `RLEE_ASSERT(a_cfg_ready, i_clk, i_rst_n, i_cfg_valid |-> o_cfg_ready)

endmodule

bind run_length_escape_encoder_core rlee_checker u_rlee_checker (.*);

`default_nettype wire
